// ----- hw/rtl/sumpcp_pkg.sv -----
// Package for the SUMP command parser: command codes, event codes and
// trigger mode codes. No dependencies.
package sumpcp_pkg;

   // Short commands
   localparam logic [7:0] CMD_RESET    = 8'h00;
   localparam logic [7:0] CMD_RUN      = 8'h01;
   localparam logic [7:0] CMD_ID       = 8'h02;
   localparam logic [7:0] CMD_METADATA = 8'h04;

   // Long commands
   localparam logic [7:0] CMD_DIVIDER  = 8'h80;
   localparam logic [7:0] CMD_COUNTS   = 8'h81;
   localparam logic [7:0] CMD_FLAGS    = 8'h82;
   localparam logic [7:0] CMD_MASK     = 8'hC0;
   localparam logic [7:0] CMD_VALUE    = 8'hC1;
   localparam logic [7:0] CMD_TRIGGER  = 8'hC2;

   localparam int unsigned EVENT_WIDTH = 3;
   localparam int unsigned MODE_WIDTH  = 2;

   typedef logic [EVENT_WIDTH-1:0] event_type;
   typedef logic [MODE_WIDTH-1:0]  mode_type;

   localparam event_type EV_NONE     = 3'd0;
   localparam event_type EV_RESET    = 3'd1;
   localparam event_type EV_RUN      = 3'd2;
   localparam event_type EV_ID       = 3'd3;
   localparam event_type EV_METADATA = 3'd4;
   localparam event_type EV_CONFIG   = 3'd5;

   localparam mode_type MODE_NONE  = 2'd0;
   localparam mode_type MODE_EDGE  = 2'd1;
   localparam mode_type MODE_LEVEL = 2'd2;

   // Last argument byte index of a long command
   localparam logic [1:0] ARG_LAST = 2'd3;

endpackage

// ----- hw/rtl/sump_command_parser.sv -----
// SUMP command parser top level: byte stream in, event and settings out.
// Depends on sumpcp_pkg.

// Takes one host command byte per clock on the req_ stream and returns one
// result per byte on the rsp_ stream: an event code for that byte together
// with the capture settings as they stand after it. Throughput is one byte
// per cycle while results are taken. Each byte passes through the input
// register, then the decode into the settings register, which is also
// the result register. The input stalls only while both registers hold
// a byte and the result is not taken. A byte with bit 7
// set opens a long command whose four little-endian argument bytes follow;
// the command takes effect on the fourth. Short command 0x00 clears all
// settings. rsp_tdata fields, lowest bit first: event_res[2:0],
// divider[23:0], rd_total[18:0], post_total[18:0], flag_word[31:0],
// trig_mask[31:0], trig_value[31:0], trig_mode[1:0], 5 zero bits.
module sump_command_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // rx_byte[7:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [167:0] rsp_tdata    // event_res, divider, rd_total, post_total,
                                     // flag_word, trig_mask, trig_value,
                                     // trig_mode, zero fill
);

   logic                   s1_valid_ff, s1_valid_in;
   logic [7:0]             s1_byte_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_free, s2_load;

   logic                   in_arg_ff, in_arg_in;
   logic [7:0]             pending_ff, pending_in;
   logic [1:0]             arg_count_ff, arg_count_in;
   logic [7:0]             arg_buf_ff [3];
   logic                   arg_wr;

   sumpcp_pkg::event_type  event_ff, event_in;
   logic [23:0]            divider_ff, divider_in;
   logic [18:0]            rd_total_ff, rd_total_in;
   logic [18:0]            post_total_ff, post_total_in;
   logic [31:0]            flags_ff, flags_in;
   logic [31:0]            mask_ff, mask_in;
   logic [31:0]            value_ff, value_in;
   sumpcp_pkg::mode_type   mode_ff, mode_in;

   logic [31:0]            arg;
   logic [16:0]            read_sum, delay_sum;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign s2_load     = s1_valid_ff && out_free;
   assign req_tready  = !s1_valid_ff || out_free;
   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !out_free);
   assign rsp_valid_in = s2_load || (rsp_valid_ff && !rsp_tready);

   assign arg       = {s1_byte_ff, arg_buf_ff[2], arg_buf_ff[1], arg_buf_ff[0]};
   assign read_sum  = {1'b0, arg[15:0]} + 17'd1;
   assign delay_sum = {1'b0, arg[31:16]} + 17'd1;

   always_comb begin
      in_arg_in      = in_arg_ff;
      pending_in     = pending_ff;
      arg_count_in   = arg_count_ff;
      arg_wr         = 1'b0;
      event_in       = sumpcp_pkg::EV_NONE;
      divider_in     = divider_ff;
      rd_total_in    = rd_total_ff;
      post_total_in  = post_total_ff;
      flags_in       = flags_ff;
      mask_in        = mask_ff;
      value_in       = value_ff;
      mode_in        = mode_ff;
      if (!in_arg_ff) begin
         if (s1_byte_ff[7]) begin
            pending_in   = s1_byte_ff;
            arg_count_in = 2'd0;
            in_arg_in    = 1'b1;
         end else begin
            unique case (s1_byte_ff)
               sumpcp_pkg::CMD_RESET: begin
                  event_in       = sumpcp_pkg::EV_RESET;
                  pending_in     = 8'd0;
                  arg_count_in   = 2'd0;
                  divider_in     = '0;
                  rd_total_in    = '0;
                  post_total_in  = '0;
                  flags_in       = '0;
                  mask_in        = '0;
                  value_in       = '0;
                  mode_in        = sumpcp_pkg::MODE_NONE;
               end
               sumpcp_pkg::CMD_RUN:      event_in = sumpcp_pkg::EV_RUN;
               sumpcp_pkg::CMD_ID:       event_in = sumpcp_pkg::EV_ID;
               sumpcp_pkg::CMD_METADATA: event_in = sumpcp_pkg::EV_METADATA;
               default:                  event_in = sumpcp_pkg::EV_NONE;
            endcase
         end
      end else if (arg_count_ff == sumpcp_pkg::ARG_LAST) begin
         in_arg_in    = 1'b0;
         arg_count_in = 2'd0;
         event_in     = sumpcp_pkg::EV_CONFIG;
         unique case (pending_ff)
            sumpcp_pkg::CMD_DIVIDER: divider_in = arg[23:0];
            sumpcp_pkg::CMD_COUNTS: begin
               rd_total_in   = {read_sum, 2'b00};
               post_total_in = {delay_sum, 2'b00};
            end
            sumpcp_pkg::CMD_FLAGS:   flags_in = arg;
            sumpcp_pkg::CMD_MASK:    mask_in  = arg;
            sumpcp_pkg::CMD_VALUE:   value_in = arg;
            sumpcp_pkg::CMD_TRIGGER:
               mode_in = arg[0] ? sumpcp_pkg::MODE_LEVEL : sumpcp_pkg::MODE_EDGE;
            default: event_in = sumpcp_pkg::EV_NONE;
         endcase
      end else begin
         arg_wr       = 1'b1;
         arg_count_in = arg_count_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         in_arg_ff      <= 1'b0;
         pending_ff     <= 8'd0;
         arg_count_ff   <= 2'd0;
         event_ff       <= sumpcp_pkg::EV_NONE;
         divider_ff     <= '0;
         rd_total_ff    <= '0;
         post_total_ff  <= '0;
         flags_ff       <= '0;
         mask_ff        <= '0;
         value_ff       <= '0;
         mode_ff        <= sumpcp_pkg::MODE_NONE;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s2_load) begin
            in_arg_ff      <= in_arg_in;
            pending_ff     <= pending_in;
            arg_count_ff   <= arg_count_in;
            event_ff       <= event_in;
            divider_ff     <= divider_in;
            rd_total_ff    <= rd_total_in;
            post_total_ff  <= post_total_in;
            flags_ff       <= flags_in;
            mask_ff        <= mask_in;
            value_ff       <= value_in;
            mode_ff        <= mode_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata;
      end
      if (s2_load && arg_wr) begin
         arg_buf_ff[arg_count_ff] <= s1_byte_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, mode_ff, value_ff, mask_ff, flags_ff,
                        post_total_ff, rd_total_ff, divider_ff, event_ff};

   // Checks
   a_count_only_in_arg: assert property (@(posedge clock) disable iff (reset)
      arg_count_ff != 2'd0 |-> in_arg_ff)
      else $error("argument count set outside an argument");

   a_reset_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && event_ff == sumpcp_pkg::EV_RESET |->
         divider_ff == '0 && rd_total_ff == '0 && post_total_ff == '0 &&
         flags_ff == '0 && mask_ff == '0 && value_ff == '0 &&
         mode_ff == sumpcp_pkg::MODE_NONE && !in_arg_ff)
      else $error("reset command left settings behind");

   a_config_ends_arg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && event_ff == sumpcp_pkg::EV_CONFIG |-> !in_arg_ff)
      else $error("config event while still collecting arguments");

   a_counts_aligned: assert property (@(posedge clock) disable iff (reset)
      rd_total_ff[1:0] == 2'b00 && post_total_ff[1:0] == 2'b00)
      else $error("sample counts not a multiple of four");

   a_output_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

endmodule
